[hdl/cu_pkg.sv]
// Shared widths, codes and types for the combination unranker.
package cu_pkg;

  localparam int RANK_W         = 44;
  localparam int COEF_W         = 44;
  localparam int IDX_W          = 11;
  localparam int UNIT_CNT_W     = 11;
  localparam int SUBSET_W       = 3;
  localparam int NUM_SLOTS      = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 11;
  localparam int DEF_MAX_UNITS  = 1024;
  localparam int DEF_MAX_SUBSET = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT_COUNT  = 1'b0,
    REG_SUBSET_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_FIN
  } cu_state_t;

endpackage

[hdl/combination_unranker_core.sv]
// Top level: combination unranker, rank in, ascending k-subset of n units out.
//
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 = unit
// count n, 1 = subset size k) at once; write only while no word is in flight.
// Input: in_valid/in_ready carry a one-based rank. Output: out_valid/out_ready
// carry five signed indices (unused slots -1) and rank_error. A rank of 0, a
// rank above C(n,k) or a bad n/k gives rank_error with all indices -1.
// Steps: ST_CHECK tests the rank, ST_WALK picks (ending early once the last
// pick is made; a bad rank skips it), ST_FIN loads the output register.
// One rank is in work at a time; the walk looks at one unit position per
// cycle with one read of the binomial memory.
// The output register lets the next rank be taken while a result waits; if
// the receiver stalls, the finished rank holds in the last step until the
// output register frees up.
// Reset: a build pass fills all MAX_UNITS + 1 rows of the binomial memory one
// row per cycle, with in_ready low; configuration writes are taken.
module combination_unranker_core #(
  parameter int MAX_UNITS  = cu_pkg::DEF_MAX_UNITS,
  parameter int MAX_SUBSET = cu_pkg::DEF_MAX_SUBSET
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cu_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cu_pkg::RANK_W-1:0]            in_rank,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cu_pkg::IDX_W-1:0]      out_index_0,
  output logic signed [cu_pkg::IDX_W-1:0]      out_index_1,
  output logic signed [cu_pkg::IDX_W-1:0]      out_index_2,
  output logic signed [cu_pkg::IDX_W-1:0]      out_index_3,
  output logic signed [cu_pkg::IDX_W-1:0]      out_index_4,
  output logic                                 out_rank_error
);
  import cu_pkg::*;

  localparam int AW    = $clog2(MAX_UNITS + 1);
  localparam int CMP_W = (AW > SUBSET_W) ? AW : SUBSET_W;

  cu_state_t state_r, state_nxt;

  logic [UNIT_CNT_W-1:0] unit_count_r;
  logic [SUBSET_W-1:0]   subset_size_r;
  logic                  cfg_ok;

  logic [RANK_W-1:0]     rank_r, rank_nxt;
  logic [RANK_W-1:0]     rem_r, rem_nxt;
  logic [AW-1:0]         m_r, m_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [SUBSET_W-1:0]   left_r, left_nxt;
  logic [SUBSET_W-1:0]   slot_r, slot_nxt;
  logic [IDX_W-1:0]      slots_r [NUM_SLOTS];
  logic [IDX_W-1:0]      slots_nxt [NUM_SLOTS];
  logic                  err_r, err_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;
  logic [IDX_W-1:0]      out_idx_r [NUM_SLOTS];
  logic                  out_err_r;

  logic [AW-1:0]                     rd_addr;
  logic [MAX_SUBSET-1:0][COEF_W-1:0] rd_row_r;
  logic                              fill_done;
  logic [COEF_W-1:0]                 coef;
  logic                              take;

  cu_binom_rom #(
    .MAX_UNITS  (MAX_UNITS),
    .MAX_SUBSET (MAX_SUBSET),
    .AW         (AW)
  ) u_rom (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_row_r  (rd_row_r),
    .fill_done (fill_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r  <= UNIT_CNT_W'(1);
      subset_size_r <= SUBSET_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UNIT_COUNT:  unit_count_r  <= cfg_wdata;
        REG_SUBSET_SIZE: subset_size_r <= cfg_wdata[SUBSET_W-1:0];
      endcase
    end
  end

  assign cfg_ok = (unit_count_r != '0) && (unit_count_r <= UNIT_CNT_W'(MAX_UNITS)) &&
                  (subset_size_r != '0) && (subset_size_r <= SUBSET_W'(MAX_SUBSET)) &&
                  (UNIT_CNT_W'(subset_size_r) <= unit_count_r);

  function automatic logic [COEF_W-1:0] coef_total(
    input logic [MAX_SUBSET-1:0][COEF_W-1:0] row,
    input logic [SUBSET_W-1:0]               k
  );
    logic [COEF_W-1:0] v;
    v = '0;
    for (int c = 0; c < MAX_SUBSET; c++) begin
      if (k == SUBSET_W'(c + 1)) begin
        v = row[c];
      end
    end
    return v;
  endfunction

  // C(m, left) from the row read for the current position
  always_comb begin
    coef = '0;
    for (int c = 0; c < MAX_SUBSET; c++) begin
      if (left_r == SUBSET_W'(c + 1)) begin
        coef = rd_row_r[c];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rank_nxt  = rank_r;
    rem_nxt   = rem_r;
    m_nxt     = m_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    slot_nxt  = slot_r;
    slots_nxt = slots_r;
    err_nxt   = err_r;
    out_load  = 1'b0;
    take      = 1'b0;
    in_ready  = 1'b0;
    rd_addr   = unit_count_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        in_ready = fill_done;
        rd_addr  = unit_count_r[AW-1:0];
        if (in_valid && fill_done) begin
          rank_nxt  = in_rank;
          for (int j = 0; j < NUM_SLOTS; j++) begin
            slots_nxt[j] = '1;
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // rd_row_r holds row n here
        rd_addr  = AW'(unit_count_r[AW-1:0] - 1'b1);
        m_nxt    = AW'(unit_count_r[AW-1:0] - 1'b1);
        pos_nxt  = '0;
        left_nxt = subset_size_r;
        slot_nxt = '0;
        rem_nxt  = rank_r;
        if (!cfg_ok || (rank_r == '0) || (rank_r > coef_total(rd_row_r, subset_size_r))) begin
          err_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          err_nxt   = 1'b0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_addr = m_r - 1'b1;
        if (left_r == '0) begin
          take = 1'b0;
        end else if (CMP_W'(m_r) < CMP_W'(left_r)) begin
          take = 1'b1;
        end else begin
          take = coef < rem_r;
          if (take) begin
            rem_nxt = rem_r - coef;
          end
        end
        if (take) begin
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (slot_r == SUBSET_W'(j)) begin
              slots_nxt[j] = IDX_W'(pos_r);
            end
          end
          slot_nxt = slot_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end
        m_nxt   = m_r - 1'b1;
        pos_nxt = pos_r + 1'b1;
        if ((take && (left_r == SUBSET_W'(1))) || (left_r == '0) || (m_r == '0)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r  <= rank_nxt;
    rem_r   <= rem_nxt;
    m_r     <= m_nxt;
    pos_r   <= pos_nxt;
    left_r  <= left_nxt;
    slot_r  <= slot_nxt;
    slots_r <= slots_nxt;
    err_r   <= err_nxt;
    if (out_load) begin
      out_idx_r <= slots_r;
      out_err_r <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_index_0    = out_idx_r[0];
  assign out_index_1    = out_idx_r[1];
  assign out_index_2    = out_idx_r[2];
  assign out_index_3    = out_idx_r[3];
  assign out_index_4    = out_idx_r[4];
  assign out_rank_error = out_err_r;

`ifndef SYNTH
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_CHECK)
    else $error("accepted word did not start the rank check");

  a_pick_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> (slot_r + left_r) == subset_size_r)
    else $error("picks made plus picks left differ from subset size");

  a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> left_r != '0)
    else $error("walk running with no picks left");

  a_err_indices: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rank_error |-> (out_index_0 == '1) && (out_index_1 == '1) &&
      (out_index_2 == '1) && (out_index_3 == '1) && (out_index_4 == '1))
    else $error("error word carries a chosen index");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && !out_ready |=> state_r == ST_FIN && out_valid_r)
    else $error("finished rank left while output register was full");
`endif

endmodule

[hdl/cu_binom_rom.sv]
// Binomial coefficient row memory, built row by row after reset.
module cu_binom_rom #(
  parameter int MAX_UNITS  = cu_pkg::DEF_MAX_UNITS,
  parameter int MAX_SUBSET = cu_pkg::DEF_MAX_SUBSET,
  parameter int AW         = $clog2(MAX_UNITS + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic [AW-1:0]                             rd_addr,
  output logic [MAX_SUBSET-1:0][cu_pkg::COEF_W-1:0] rd_row_r,
  output logic                                      fill_done
);
  import cu_pkg::*;

  localparam int DEPTH = MAX_UNITS + 1;

  // column c of a word holds C(row, c+1); C(row, 0) is always 1 and not stored
  logic [MAX_SUBSET-1:0][COEF_W-1:0] mem [DEPTH];

  logic [AW-1:0]                     fill_addr_r;
  logic                              filling_r;
  logic [MAX_SUBSET-1:0][COEF_W-1:0] prev_r;
  logic [MAX_SUBSET-1:0][COEF_W-1:0] new_row;

  always_comb begin
    // C(r,1) = C(r-1,1) + C(r-1,0), where C(-1,0) counts as 0
    new_row[0] = prev_r[0] + ((fill_addr_r != '0) ? COEF_W'(1) : COEF_W'(0));
    for (int c = 1; c < MAX_SUBSET; c++) begin
      new_row[c] = prev_r[c] + prev_r[c-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_addr_r <= '0;
      filling_r   <= 1'b1;
      prev_r      <= '0;
    end else if (filling_r) begin
      prev_r      <= new_row;
      fill_addr_r <= fill_addr_r + 1'b1;
      if (fill_addr_r == AW'(MAX_UNITS)) begin
        filling_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (filling_r) begin
      mem[fill_addr_r] <= new_row;
    end
    rd_row_r <= mem[rd_addr];
  end

  assign fill_done = !filling_r;

endmodule
